### design/mask_bbox_roi_bounds_unit_assert.svh
// assertion macros for the mask bounding box region bounds unit
`ifndef MASK_BBOX_ROI_BOUNDS_UNIT_ASSERT_SVH
`define MASK_BBOX_ROI_BOUNDS_UNIT_ASSERT_SVH

// property checked at every clock edge outside reset
`define MBRB_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// consequent checked in the cycle after the antecedent
`define MBRB_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/mbrb_pkg.sv
// shared types, constants and helper functions of the region bounds unit
`timescale 1ns / 1ps

package mbrb_pkg;

  localparam int MAX_DIM         = 1024;
  localparam int RATIO_FRAC_BITS = 8;

  localparam int POS_W      = 10;
  localparam int CNT_W      = 11;
  localparam int RATIO_W    = 16;
  localparam int MODE_W     = 3;
  localparam int HALF_W     = 10;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int NUM_AXES   = 3;
  localparam int AXIS_W     = $clog2(NUM_AXES);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // fixed point widths of the ratio extension path
  localparam int SCALE_SH = RATIO_FRAC_BITS + 1;
  localparam int SPAN_W   = POS_W + 1;
  localparam int PROD_W   = SPAN_W + RATIO_W;
  localparam int EXT_W    = POS_W + SCALE_SH + 2;
  localparam int SAT_W    = EXT_W + 4;
  localparam int WIDE_W   = PROD_W + 2;
  localparam int LO_W     = POS_W + 3;

  localparam logic [MODE_W-1:0] MODE_ABOVE   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_BELOW   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_BETWEEN = 3'd3;
  localparam logic [MODE_W-1:0] MODE_RATIO   = 3'd4;
  localparam logic [MODE_W-1:0] MODE_FIXED   = 3'd5;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROI_MODE     = 3'd0,
    REG_ROW_COUNT    = 3'd1,
    REG_COL_COUNT    = 3'd2,
    REG_SLICE_COUNT  = 3'd3,
    REG_EXTEND_RATIO = 3'd4,
    REG_CUBE_FLAG    = 3'd5,
    REG_HALF_EXTENT  = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic [MODE_W-1:0]  roi_mode;
    logic [CNT_W-1:0]   row_count;
    logic [CNT_W-1:0]   col_count;
    logic [CNT_W-1:0]   slice_count;
    logic [RATIO_W-1:0] extend_ratio;
    logic               cube_flag;
    logic [HALF_W-1:0]  half_extent;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    roi_mode:     MODE_BETWEEN,
    row_count:    CNT_W'(MAX_DIM),
    col_count:    CNT_W'(MAX_DIM),
    slice_count:  CNT_W'(MAX_DIM),
    extend_ratio: RATIO_W'(1 << RATIO_FRAC_BITS),
    cube_flag:    1'b0,
    half_extent:  '0
  };

  // axis 0 rows, 1 columns, 2 slices
  typedef struct packed {
    logic [NUM_AXES-1:0][POS_W-1:0] min_pos;
    logic [NUM_AXES-1:0][POS_W-1:0] max_pos;
    logic                           any_found;
  } box_t;

  localparam box_t BOX_CLEAR = '{min_pos: '1, max_pos: '0, any_found: 1'b0};

  typedef struct packed {
    logic [NUM_AXES-1:0][POS_W-1:0] low;
    logic [NUM_AXES-1:0][POS_W-1:0] high;
    logic                           status;
  } res_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic [POS_W-1:0] eff_limit(input logic [CNT_W-1:0] c);
    logic [POS_W-1:0] r;
    if (c == '0) begin
      r = '0;
    end else if (32'(c) > MAX_DIM) begin
      r = POS_W'(MAX_DIM - 1);
    end else begin
      r = POS_W'(c - CNT_W'(1));
    end
    return r;
  endfunction

  function automatic logic [POS_W-1:0] sat(input logic signed [SAT_W-1:0] v,
                                           input logic [POS_W-1:0] lim);
    logic signed [SAT_W-1:0] lim_s;
    logic [POS_W-1:0]        r;
    lim_s = $signed(SAT_W'(lim));
    if (v < 0) begin
      r = '0;
    end else if (v > lim_s) begin
      r = lim;
    end else begin
      r = v[POS_W-1:0];
    end
    return r;
  endfunction

  // divide by the scale, rounding toward zero
  function automatic logic signed [SAT_W-1:0] trunc_div(input logic signed [SAT_W-1:0] v);
    logic signed [SAT_W-1:0] bias;
    bias = v[SAT_W-1] ? SAT_W'((1 << SCALE_SH) - 1) : '0;
    return (v + bias) >>> SCALE_SH;
  endfunction

endpackage

### design/mbrb_box_queue.sv
// short queue of finished boxes between the voxel front and the bounds back
`timescale 1ns / 1ps

module mbrb_box_queue import mbrb_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  box_t    data_i,
  input  logic    pop_i,
  output box_t    data_o,
  output q_stat_t stat_o
);

  box_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign stat_o.full  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign data_o       = mem_q[rd_q];

  assign do_push = push_i && !stat_o.full;
  assign do_pop  = pop_i && !stat_o.empty;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + QPTR_W'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + QPTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

### design/mbrb_front.sv
// voxel front: tracks the bounding box and hands it over on the last voxel
`timescale 1ns / 1ps

module mbrb_front import mbrb_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic [POS_W-1:0] row_pos_i,
  input  logic [POS_W-1:0] col_pos_i,
  input  logic [POS_W-1:0] slice_pos_i,
  input  logic             inside_req_i,
  input  logic             last_voxel_i,
  output logic             push_o,
  output box_t             box_o
);

  box_t                           box_q, box_d, upd;
  logic [NUM_AXES-1:0][POS_W-1:0] pos;

  assign pos = {slice_pos_i, col_pos_i, row_pos_i};

  always_comb begin
    upd = box_q;
    if (inside_req_i) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        if (pos[a] < box_q.min_pos[a]) begin
          upd.min_pos[a] = pos[a];
        end
        if (pos[a] > box_q.max_pos[a]) begin
          upd.max_pos[a] = pos[a];
        end
      end
      upd.any_found = 1'b1;
    end
  end

  assign push_o = accept_i && last_voxel_i;
  assign box_o  = upd;

  always_comb begin
    box_d = box_q;
    if (accept_i) begin
      box_d = last_voxel_i ? BOX_CLEAR : upd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_q <= BOX_CLEAR;
    end else begin
      box_q <= box_d;
    end
  end

endmodule

### design/mbrb_back.sv
// bounds back: turns one finished box into crop bounds per mode
`timescale 1ns / 1ps

module mbrb_back import mbrb_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cfg_t    cfg_i,
  input  q_stat_t q_stat_i,
  input  box_t    q_data_i,
  output logic    q_pop_o,
  input  logic    pop_i,
  output logic    res_valid_o,
  output res_t    res_o
);

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_MUL    = 7'b0000010,
    ST_CLAMP  = 7'b0000100,
    ST_CUBE   = 7'b0001000,
    ST_LOW    = 7'b0010000,
    ST_HIGH   = 7'b0100000,
    ST_DIRECT = 7'b1000000
  } state_e;

  localparam logic [AXIS_W-1:0] LAST_AXIS = AXIS_W'(NUM_AXES - 1);

  state_e                  state_q, state_d;
  box_t                    box_q, box_d;
  logic [AXIS_W-1:0]       axis_q, axis_d;
  logic [PROD_W-1:0]       prod_q, prod_d;
  logic signed [EXT_W-1:0] ext_q [NUM_AXES];
  logic signed [EXT_W-1:0] ext_d [NUM_AXES];
  logic signed [LO_W-1:0]  lo_q [NUM_AXES];
  logic signed [LO_W-1:0]  lo_d [NUM_AXES];
  res_t                    res_q, res_d;
  logic                    res_valid_q, res_valid_d;

  logic [NUM_AXES-1:0][CNT_W-1:0] cnt;
  logic [NUM_AXES-1:0][POS_W-1:0] lim;
  logic [POS_W:0]                 csum [NUM_AXES];
  logic signed [SAT_W-1:0]        cent_s [NUM_AXES];
  logic signed [SAT_W-1:0]        lim_s [NUM_AXES];
  logic signed [SAT_W-1:0]        half_s;
  logic [SPAN_W-1:0]              span;
  logic signed [SAT_W-1:0]        up, min_s, up_sc;
  logic signed [EXT_W-1:0]        big;
  logic signed [SAT_W-1:0]        num, num_hi;

  assign cnt    = {cfg_i.slice_count, cfg_i.col_count, cfg_i.row_count};
  assign half_s = $signed(SAT_W'(cfg_i.half_extent));

  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      lim[a]    = eff_limit(cnt[a]);
      lim_s[a]  = $signed(SAT_W'(lim[a]));
      csum[a]   = {1'b0, box_q.min_pos[a]} + {1'b0, box_q.max_pos[a]};
      cent_s[a] = $signed(SAT_W'(csum[a][POS_W:1]));
    end
  end

  always_comb begin
    state_d     = state_q;
    box_d       = box_q;
    axis_d      = axis_q;
    prod_d      = prod_q;
    ext_d       = ext_q;
    lo_d        = lo_q;
    res_d       = res_q;
    res_valid_d = res_valid_q;
    q_pop_o     = 1'b0;
    span        = '0;
    up          = '0;
    min_s       = '0;
    up_sc       = '0;
    big         = '0;
    num         = '0;
    num_hi      = '0;

    if (pop_i) begin
      res_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (!q_stat_i.empty && !res_valid_q) begin
          q_pop_o = 1'b1;
          box_d   = q_data_i;
          axis_d  = '0;
          state_d = (q_data_i.any_found && cfg_i.roi_mode == MODE_RATIO) ? ST_MUL : ST_DIRECT;
        end
      end
      ST_MUL: begin
        span    = SPAN_W'({1'b0, box_q.max_pos[axis_q]}) -
                  SPAN_W'({1'b0, box_q.min_pos[axis_q]}) + SPAN_W'(1);
        prod_d  = PROD_W'(span) * PROD_W'(cfg_i.extend_ratio);
        state_d = ST_CLAMP;
      end
      ST_CLAMP: begin
        // extension limited by the distance to the nearer edge
        up    = lim_s[axis_q] - $signed(SAT_W'(box_q.max_pos[axis_q]));
        min_s = $signed(SAT_W'(box_q.min_pos[axis_q]));
        if (up > min_s) begin
          up = min_s;
        end
        up_sc = up <<< SCALE_SH;
        if ($signed(WIDE_W'(prod_q)) > WIDE_W'(up_sc)) begin
          ext_d[axis_q] = EXT_W'(up_sc);
        end else begin
          ext_d[axis_q] = $signed(EXT_W'(prod_q));
        end
        if (axis_q == LAST_AXIS) begin
          axis_d  = '0;
          state_d = ST_CUBE;
        end else begin
          axis_d  = axis_q + AXIS_W'(1);
          state_d = ST_MUL;
        end
      end
      ST_CUBE: begin
        big = ext_q[0];
        for (int a = 1; a < NUM_AXES; a++) begin
          if (ext_q[a] > big) begin
            big = ext_q[a];
          end
        end
        if (cfg_i.cube_flag) begin
          for (int a = 0; a < NUM_AXES; a++) begin
            ext_d[a] = big;
          end
        end
        state_d = ST_LOW;
      end
      ST_LOW: begin
        for (int a = 0; a < NUM_AXES; a++) begin
          num     = (cent_s[a] <<< SCALE_SH) - SAT_W'(ext_q[a]);
          lo_d[a] = LO_W'(trunc_div(num));
        end
        state_d = ST_HIGH;
      end
      ST_HIGH: begin
        for (int a = 0; a < NUM_AXES; a++) begin
          num_hi        = (SAT_W'(lo_q[a]) <<< SCALE_SH) + (SAT_W'(ext_q[a]) <<< 1);
          res_d.low[a]  = sat(SAT_W'(lo_q[a]), lim[a]);
          res_d.high[a] = sat(trunc_div(num_hi), lim[a]);
        end
        res_d.status = 1'b0;
        res_valid_d  = 1'b1;
        state_d      = ST_IDLE;
      end
      ST_DIRECT: begin
        if (!box_q.any_found) begin
          res_d        = '0;
          res_d.status = 1'b1;
        end else if (cfg_i.roi_mode == MODE_FIXED) begin
          for (int a = 0; a < NUM_AXES; a++) begin
            res_d.low[a]  = sat(cent_s[a] - half_s, lim[a]);
            res_d.high[a] = sat(cent_s[a] + half_s, lim[a]);
          end
          res_d.status = 1'b0;
        end else begin
          // rows and columns span the whole image
          for (int a = 0; a < NUM_AXES - 1; a++) begin
            res_d.low[a]  = '0;
            res_d.high[a] = lim[a];
          end
          priority if (cfg_i.roi_mode == MODE_ABOVE) begin
            res_d.low[NUM_AXES-1]  = sat(SAT_W'(box_q.max_pos[NUM_AXES-1]), lim[NUM_AXES-1]);
            res_d.high[NUM_AXES-1] = lim[NUM_AXES-1];
          end else if (cfg_i.roi_mode == MODE_BELOW) begin
            res_d.low[NUM_AXES-1]  = '0;
            res_d.high[NUM_AXES-1] = sat(SAT_W'(box_q.min_pos[NUM_AXES-1]), lim[NUM_AXES-1]);
          end else begin
            res_d.low[NUM_AXES-1]  = sat(SAT_W'(box_q.min_pos[NUM_AXES-1]), lim[NUM_AXES-1]);
            res_d.high[NUM_AXES-1] = sat(SAT_W'(box_q.max_pos[NUM_AXES-1]), lim[NUM_AXES-1]);
          end
          res_d.status = 1'b0;
        end
        res_valid_d = 1'b1;
        state_d     = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      axis_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      axis_q      <= axis_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    box_q  <= box_d;
    prod_q <= prod_d;
    ext_q  <= ext_d;
    lo_q   <= lo_d;
    res_q  <= res_d;
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

### design/mask_bbox_roi_bounds_unit.sv
// Mask bounding box region bounds unit, top level.
// Voxels are taken one per cycle with no stall while the box queue has room.
// After the last voxel, a result in mode 4 passes through three shared multiply
// and clamp steps, then cube, low and high steps; every other mode and a blank
// mask take the single direct step of the bounds sequencer.
// Reset clears the box, the queue, the result valid flag and loads the default
// configuration; nothing else is needed before the first voxel.
`timescale 1ns / 1ps

module mask_bbox_roi_bounds_unit import mbrb_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_addr_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  push,
  output logic                  full,
  input  logic [POS_W-1:0]      row_pos_i,
  input  logic [POS_W-1:0]      col_pos_i,
  input  logic [POS_W-1:0]      slice_pos_i,
  input  logic                  inside_req_i,
  input  logic                  last_voxel_i,
  output logic                  empty,
  input  logic                  pop,
  output logic [POS_W-1:0]      row_low_o,
  output logic [POS_W-1:0]      row_high_o,
  output logic [POS_W-1:0]      col_low_o,
  output logic [POS_W-1:0]      col_high_o,
  output logic [POS_W-1:0]      slice_low_o,
  output logic [POS_W-1:0]      slice_high_o,
  output logic                  status_o
);

  cfg_t    cfg_q, cfg_d;
  logic    accept, front_push, q_pop, res_valid;
  box_t    front_box, q_data;
  q_stat_t q_stat;
  res_t    res;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_ROI_MODE:     cfg_d.roi_mode     = cfg_wdata_i[MODE_W-1:0];
        REG_ROW_COUNT:    cfg_d.row_count    = cfg_wdata_i[CNT_W-1:0];
        REG_COL_COUNT:    cfg_d.col_count    = cfg_wdata_i[CNT_W-1:0];
        REG_SLICE_COUNT:  cfg_d.slice_count  = cfg_wdata_i[CNT_W-1:0];
        REG_EXTEND_RATIO: cfg_d.extend_ratio = cfg_wdata_i[RATIO_W-1:0];
        REG_CUBE_FLAG:    cfg_d.cube_flag    = cfg_wdata_i[0];
        REG_HALF_EXTENT:  cfg_d.half_extent  = cfg_wdata_i[HALF_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign full   = q_stat.full;
  assign accept = push && !q_stat.full;

  mbrb_front u_front (
    .clk_i,
    .rst_ni,
    .accept_i (accept),
    .row_pos_i,
    .col_pos_i,
    .slice_pos_i,
    .inside_req_i,
    .last_voxel_i,
    .push_o   (front_push),
    .box_o    (front_box)
  );

  mbrb_box_queue u_queue (
    .clk_i,
    .rst_ni,
    .push_i (front_push),
    .data_i (front_box),
    .pop_i  (q_pop),
    .data_o (q_data),
    .stat_o (q_stat)
  );

  mbrb_back u_back (
    .clk_i,
    .rst_ni,
    .cfg_i       (cfg_q),
    .q_stat_i    (q_stat),
    .q_data_i    (q_data),
    .q_pop_o     (q_pop),
    .pop_i       (pop && res_valid),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  assign empty        = !res_valid;
  assign row_low_o    = res.low[0];
  assign row_high_o   = res.high[0];
  assign col_low_o    = res.low[1];
  assign col_high_o   = res.high[1];
  assign slice_low_o  = res.low[2];
  assign slice_high_o = res.high[2];
  assign status_o     = res.status;

endmodule

### design/mbrb_checker.sv
// port level checks of the region bounds unit and their binding
`timescale 1ns / 1ps

`include "mask_bbox_roi_bounds_unit_assert.svh"

module mbrb_checker import mbrb_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             push,
  input logic             full,
  input logic             empty,
  input logic             pop,
  input logic [POS_W-1:0] row_low_o,
  input logic [POS_W-1:0] row_high_o,
  input logic [POS_W-1:0] col_low_o,
  input logic [POS_W-1:0] col_high_o,
  input logic [POS_W-1:0] slice_low_o,
  input logic [POS_W-1:0] slice_high_o,
  input logic             status_o
);

  // a waiting item keeps its status, row low and slice high bounds until taken
  `MBRB_ASSERT_NEXT(a_result_held, clk_i, rst_ni, !empty && !pop,
    !empty && $stable(status_o) && $stable(row_low_o) && $stable(slice_high_o),
    "result changed while waiting")

  // blank mask reports all bounds as zero
  `MBRB_ASSERT(a_blank_zero, clk_i, rst_ni,
    (!empty && status_o) |-> (row_low_o == 0 && row_high_o == 0 && col_low_o == 0 &&
    col_high_o == 0 && slice_low_o == 0 && slice_high_o == 0),
    "blank mask with nonzero bounds")

  // queue can only fill up through an accepted voxel
  `MBRB_ASSERT_NEXT(a_full_needs_push, clk_i, rst_ni, !full && !push, !full,
    "full rose without a push")

  // no item waits right after reset
  `MBRB_ASSERT(a_reset_empty, clk_i, rst_ni, $rose(rst_ni) |-> empty,
    "result present after reset")

endmodule

bind mask_bbox_roi_bounds_unit mbrb_checker u_mbrb_checker (.*);

### verif/mask_bbox_roi_bounds_unit_test.sv
// self-checking testbench of the mask bounding box region bounds unit
`timescale 1ns / 1ps

module mask_bbox_roi_bounds_unit_test import mbrb_pkg::*; ();

  localparam int unsigned TIMEOUT_NS = 4_000_000;
  localparam int IDLE_PAD = 16;
  localparam int HOLD_CYCLES = 300;
  localparam int PRESSURE_ITEMS = 30;
  localparam int PRESSURE_PHASE = 6;
  localparam int NUM_PHASES = 14;
  localparam int PHASE_ITEMS = 62;
  localparam int MAX_REPORTS = 10;
  localparam longint HALF_DIV = 2;
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(MAX_DIM - 1);

  // mode codes outside the defined set, handled as between
  localparam logic [MODE_W-1:0] MODE_UNUSED_0 = 3'd0;
  localparam logic [MODE_W-1:0] MODE_UNUSED_6 = 3'd6;
  localparam logic [MODE_W-1:0] MODE_UNUSED_7 = 3'd7;

  localparam logic [MODE_W-1:0] PHASE_MODE [NUM_PHASES] = '{
    MODE_RATIO, MODE_RATIO, MODE_FIXED, MODE_FIXED, MODE_ABOVE, MODE_BELOW,
    MODE_BETWEEN, MODE_RATIO, MODE_UNUSED_0, MODE_FIXED, MODE_UNUSED_6,
    MODE_RATIO, MODE_UNUSED_7, MODE_RATIO
  };

  localparam res_t BLANK_RES = '{low: '0, high: '0, status: 1'b1};

  typedef struct packed {
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic [POS_W-1:0] slice;
    logic             in_mask;
    logic             last;
  } voxel_t;

  typedef struct packed {
    logic              set_mode;
    logic [MODE_W-1:0] mode;
    voxel_t            vox;
    logic              typed;
    res_t              want;
  } dir_row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_addr_i = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic                  push = 1'b0;
  logic                  full;
  logic [POS_W-1:0]      row_pos_i = '0;
  logic [POS_W-1:0]      col_pos_i = '0;
  logic [POS_W-1:0]      slice_pos_i = '0;
  logic                  inside_req_i = 1'b0;
  logic                  last_voxel_i = 1'b0;
  logic                  empty;
  logic                  pop = 1'b0;
  logic [POS_W-1:0]      row_low_o;
  logic [POS_W-1:0]      row_high_o;
  logic [POS_W-1:0]      col_low_o;
  logic [POS_W-1:0]      col_high_o;
  logic [POS_W-1:0]      slice_low_o;
  logic [POS_W-1:0]      slice_high_o;
  logic                  status_o;

  mask_bbox_roi_bounds_unit i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .push         (push),
    .full         (full),
    .row_pos_i    (row_pos_i),
    .col_pos_i    (col_pos_i),
    .slice_pos_i  (slice_pos_i),
    .inside_req_i (inside_req_i),
    .last_voxel_i (last_voxel_i),
    .empty        (empty),
    .pop          (pop),
    .row_low_o    (row_low_o),
    .row_high_o   (row_high_o),
    .col_low_o    (col_low_o),
    .col_high_o   (col_high_o),
    .slice_low_o  (slice_low_o),
    .slice_high_o (slice_high_o),
    .status_o     (status_o)
  );

  // predictor copy of configuration and box
  logic [MODE_W-1:0]  cur_mode;
  logic [CNT_W-1:0]   cur_count [NUM_AXES];
  logic [RATIO_W-1:0] cur_ratio;
  logic               cur_cube;
  logic [HALF_W-1:0]  cur_half;
  logic [POS_W-1:0]   box_min [NUM_AXES];
  logic [POS_W-1:0]   box_max [NUM_AXES];
  logic               box_any;

  res_t     bounds_q [$];
  dir_row_t dir_tab [$];

  int mismatch_cnt = 0;
  int voxel_cnt = 0;
  int mask_cnt = 0;
  int blank_cnt = 0;
  int setting_cnt = 0;
  int stall_cnt = 0;
  int burst_left = 0;
  int hold_ticket = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int cyc = 0;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("mask_bbox_roi_bounds_unit_test failed");
    $finish;
  end

  function automatic void clear_box();
    for (int a = 0; a < NUM_AXES; a++) begin
      box_min[a] = '1;
      box_max[a] = '0;
    end
    box_any = 1'b0;
  endfunction

  function automatic longint axis_limit(input logic [CNT_W-1:0] c);
    if (c == '0) return 0;
    if (c > MAX_DIM) return MAX_DIM - 1;
    return longint'(c) - 1;
  endfunction

  function automatic logic [POS_W-1:0] clamp_bound(input longint v, input longint lim);
    if (v < 0) return '0;
    if (v > lim) return POS_W'(lim);
    return POS_W'(v);
  endfunction

  function automatic res_t predict_bounds();
    longint lo [NUM_AXES];
    longint hi [NUM_AXES];
    longint lim [NUM_AXES];
    longint rl [NUM_AXES];
    longint rh [NUM_AXES];
    longint ext [NUM_AXES];
    longint cent [NUM_AXES];
    longint up;
    longint big;
    longint scale;
    res_t   r;
    scale = longint'(1) << (RATIO_FRAC_BITS + 1);
    r = '0;
    if (!box_any) return BLANK_RES;
    for (int a = 0; a < NUM_AXES; a++) begin
      lo[a] = longint'(box_min[a]);
      hi[a] = longint'(box_max[a]);
      lim[a] = axis_limit(cur_count[a]);
    end
    if (cur_mode == MODE_RATIO) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        up = lim[a] - hi[a];
        if (up > lo[a]) up = lo[a];
        cent[a] = (lo[a] + hi[a]) / HALF_DIV;
        ext[a] = (hi[a] - lo[a] + 1) * longint'(cur_ratio);
        if (ext[a] > up * scale) ext[a] = up * scale;
      end
      if (cur_cube) begin
        big = ext[0];
        for (int a = 1; a < NUM_AXES; a++) if (ext[a] > big) big = ext[a];
        for (int a = 0; a < NUM_AXES; a++) ext[a] = big;
      end
      for (int a = 0; a < NUM_AXES; a++) begin
        rl[a] = (cent[a] * scale - ext[a]) / scale;
        rh[a] = (rl[a] * scale + 2 * ext[a]) / scale;
      end
    end else if (cur_mode == MODE_FIXED) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        cent[a] = (lo[a] + hi[a]) / HALF_DIV;
        rl[a] = cent[a] - longint'(cur_half);
        rh[a] = cent[a] + longint'(cur_half);
      end
    end else begin
      for (int a = 0; a < 2; a++) begin
        rl[a] = 0;
        rh[a] = lim[a];
      end
      case (cur_mode)
        MODE_ABOVE: begin
          rl[2] = hi[2];
          rh[2] = lim[2];
        end
        MODE_BELOW: begin
          rl[2] = 0;
          rh[2] = lo[2];
        end
        default: begin
          rl[2] = lo[2];
          rh[2] = hi[2];
        end
      endcase
    end
    for (int a = 0; a < NUM_AXES; a++) begin
      r.low[a] = clamp_bound(rl[a], lim[a]);
      r.high[a] = clamp_bound(rh[a], lim[a]);
    end
    return r;
  endfunction

  task automatic track_voxel(input voxel_t v, output bit made, output res_t r);
    logic [POS_W-1:0] pos [NUM_AXES];
    pos[0] = v.row;
    pos[1] = v.col;
    pos[2] = v.slice;
    made = 1'b0;
    r = '0;
    if (v.in_mask) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        if (pos[a] < box_min[a]) box_min[a] = pos[a];
        if (pos[a] > box_max[a]) box_max[a] = pos[a];
      end
      box_any = 1'b1;
    end
    if (v.last) begin
      made = 1'b1;
      r = predict_bounds();
      clear_box();
    end
  endtask

  function automatic res_t bounds_res(input logic [POS_W-1:0] r_lo, r_hi, c_lo, c_hi,
                                      s_lo, s_hi);
    res_t r;
    r.low[0] = r_lo;
    r.high[0] = r_hi;
    r.low[1] = c_lo;
    r.high[1] = c_hi;
    r.low[2] = s_lo;
    r.high[2] = s_hi;
    r.status = 1'b0;
    return r;
  endfunction

  function automatic dir_row_t row_of(input logic set_mode, input logic [MODE_W-1:0] mode,
                                      input logic [POS_W-1:0] r, c, s,
                                      input logic in_mask, last, typed,
                                      input res_t want);
    dir_row_t d;
    d.set_mode = set_mode;
    d.mode = mode;
    d.vox = '{row: r, col: c, slice: s, in_mask: in_mask, last: last};
    d.typed = typed;
    d.want = want;
    return d;
  endfunction

  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    case (idx)
      REG_ROI_MODE:     cur_mode = data[MODE_W-1:0];
      REG_ROW_COUNT:    cur_count[0] = data[CNT_W-1:0];
      REG_COL_COUNT:    cur_count[1] = data[CNT_W-1:0];
      REG_SLICE_COUNT:  cur_count[2] = data[CNT_W-1:0];
      REG_EXTEND_RATIO: cur_ratio = data[RATIO_W-1:0];
      REG_CUBE_FLAG:    cur_cube = data[0];
      REG_HALF_EXTENT:  cur_half = data[HALF_W-1:0];
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    push <= 1'b0;
    while (bounds_q.size() != 0) @(posedge clk_i);
    repeat (IDLE_PAD) @(posedge clk_i);
  endtask

  task automatic offer_voxel(input voxel_t v, input bit steady, input bit use_want,
                             input res_t want);
    bit   made;
    res_t r;
    int   gap;
    if (!steady) begin
      if (burst_left == 0) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        if (gap > 0) begin
          push <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 16);
      end
      burst_left--;
    end
    push <= 1'b1;
    row_pos_i <= v.row;
    col_pos_i <= v.col;
    slice_pos_i <= v.slice;
    inside_req_i <= v.in_mask;
    last_voxel_i <= v.last;
    @(posedge clk_i);
    while (full) begin
      stall_cnt++;
      @(posedge clk_i);
    end
    voxel_cnt++;
    track_voxel(v, made, r);
    if (made) begin
      bounds_q.push_back(use_want ? want : r);
      mask_cnt++;
      if (r.status) blank_cnt++;
    end
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_count();
    case ($urandom_range(0, 9))
      0: return CFG_DATA_W'(MAX_DIM);
      1: return CFG_DATA_W'(1);
      2: return '0;
      3: return CFG_DATA_W'($urandom);
      default: return CFG_DATA_W'($urandom_range(1, MAX_DIM));
    endcase
  endfunction

  function automatic logic [POS_W-1:0] pick_pos(input longint center, input longint spread,
                                                input longint lim);
    longint v;
    if ($urandom_range(0, 9) == 0) return POS_W'($urandom);
    v = center - spread + longint'($urandom_range(0, int'(2 * spread)));
    if (v < 0) v = 0;
    if (v > lim) v = lim;
    return POS_W'(v);
  endfunction

  task automatic run_phase(input int p);
    logic [CFG_DATA_W-1:0] cnt [NUM_AXES];
    logic [CFG_DATA_W-1:0] ratio;
    logic [CFG_DATA_W-1:0] cube;
    logic [CFG_DATA_W-1:0] half;
    longint ctr [NUM_AXES];
    longint lim [NUM_AXES];
    longint spread;
    voxel_t v;
    int     items;
    int     len;
    bit     noise;
    case (p)
      0: begin
        cnt = '{CFG_DATA_W'(MAX_DIM), CFG_DATA_W'(MAX_DIM), CFG_DATA_W'(MAX_DIM)};
        ratio = '1;
        cube = CFG_DATA_W'(1);
        half = '0;
      end
      1: begin
        cnt = '{CFG_DATA_W'(MAX_DIM), CFG_DATA_W'($urandom_range(1, MAX_DIM)),
                CFG_DATA_W'(MAX_DIM)};
        ratio = '0;
        cube = '0;
        half = CFG_DATA_W'(MAX_DIM - 1);
      end
      2: begin
        cnt = '{CFG_DATA_W'(1), '0, '1};
        ratio = CFG_DATA_W'(1 << RATIO_FRAC_BITS);
        cube = '0;
        half = CFG_DATA_W'(MAX_DIM - 1);
      end
      3: begin
        cnt = '{CFG_DATA_W'(MAX_DIM), CFG_DATA_W'(MAX_DIM), CFG_DATA_W'(MAX_DIM)};
        ratio = '1;
        cube = '1;
        half = '0;
      end
      default: begin
        for (int a = 0; a < NUM_AXES; a++) cnt[a] = pick_count();
        case ($urandom_range(0, 3))
          0: ratio = '0;
          1: ratio = '1;
          2: ratio = CFG_DATA_W'(1 << RATIO_FRAC_BITS);
          default: ratio = CFG_DATA_W'($urandom);
        endcase
        cube = CFG_DATA_W'($urandom);
        case ($urandom_range(0, 3))
          0: half = '0;
          1: half = CFG_DATA_W'(MAX_DIM - 1);
          2: half = CFG_DATA_W'($urandom_range(0, 64));
          default: half = CFG_DATA_W'($urandom);
        endcase
      end
    endcase
    wait_idle();
    write_reg(REG_ROI_MODE, CFG_DATA_W'(PHASE_MODE[p]));
    write_reg(REG_ROW_COUNT, cnt[0]);
    write_reg(REG_COL_COUNT, cnt[1]);
    write_reg(REG_SLICE_COUNT, cnt[2]);
    write_reg(REG_EXTEND_RATIO, ratio);
    write_reg(REG_CUBE_FLAG, cube);
    write_reg(REG_HALF_EXTENT, half);
    cfg_we_i <= 1'b0;
    setting_cnt++;
    for (int a = 0; a < NUM_AXES; a++) lim[a] = axis_limit(cur_count[a]);

    // receiver holds off while single voxel masks keep coming
    if (p == PRESSURE_PHASE) begin
      hold_ticket++;
      for (int k = 0; k < PRESSURE_ITEMS; k++) begin
        v = '{row: POS_W'($urandom), col: POS_W'($urandom), slice: POS_W'($urandom),
              in_mask: 1'b1, last: 1'b1};
        offer_voxel(v, 1'b1, 1'b0, '0);
      end
    end

    items = 0;
    while (items < PHASE_ITEMS) begin
      len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 24);
      noise = ($urandom_range(0, 9) == 0);
      spread = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 300) : $urandom_range(0, 20);
      for (int a = 0; a < NUM_AXES; a++) ctr[a] = $urandom_range(0, int'(lim[a]));
      for (int k = 0; k < len; k++) begin
        v.row = pick_pos(ctr[0], spread, lim[0]);
        v.col = pick_pos(ctr[1], spread, lim[1]);
        v.slice = pick_pos(ctr[2], spread, lim[2]);
        v.in_mask = noise ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 9) < 7);
        v.last = noise ? ($urandom_range(0, 3) == 0) : (k == len - 1);
        offer_voxel(v, 1'b0, 1'b0, '0);
      end
      items += len;
    end
    // close any open mask so no box spans a configuration change
    v = '{row: POS_W'($urandom), col: POS_W'($urandom), slice: POS_W'($urandom),
          in_mask: 1'($urandom_range(0, 1)), last: 1'b1};
    offer_voxel(v, 1'b0, 1'b0, '0);
  endtask

  task automatic check_result();
    res_t got;
    res_t want;
    bit   bad;
    got.low[0] = row_low_o;
    got.high[0] = row_high_o;
    got.low[1] = col_low_o;
    got.high[1] = col_high_o;
    got.low[2] = slice_low_o;
    got.high[2] = slice_high_o;
    got.status = status_o;
    if (bounds_q.size() == 0) begin
      mismatch_cnt++;
      if (mismatch_cnt <= MAX_REPORTS)
        $display("unexpected item: rows %0d..%0d cols %0d..%0d slices %0d..%0d st %0d",
                 got.low[0], got.high[0], got.low[1], got.high[1], got.low[2],
                 got.high[2], got.status);
    end else begin
      want = bounds_q.pop_front();
      bad = (got.status !== want.status);
      for (int a = 0; a < NUM_AXES; a++) begin
        if (got.low[a] !== want.low[a]) bad = 1'b1;
        if (got.high[a] !== want.high[a]) bad = 1'b1;
      end
      if (bad) begin
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_REPORTS) begin
          $display("mismatch exp: rows %0d..%0d cols %0d..%0d slices %0d..%0d st %0d",
                   want.low[0], want.high[0], want.low[1], want.high[1], want.low[2],
                   want.high[2], want.status);
          $display("         got: rows %0d..%0d cols %0d..%0d slices %0d..%0d st %0d",
                   got.low[0], got.high[0], got.low[1], got.high[1], got.low[2],
                   got.high[2], got.status);
        end
      end
    end
  endtask

  // receiver: cycles through four stall patterns, long hold on request
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pop && !empty) check_result();
      cyc++;
      if (hold_ticket != hold_seen) begin
        hold_seen = hold_ticket;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        case ((cyc / 64) % 4)
          0: pop <= 1'b1;
          1: pop <= 1'($urandom_range(0, 1));
          2: pop <= (cyc % 5 == 0);
          default: pop <= ($urandom_range(0, 9) == 0);
        endcase
      end
    end
  end

  initial begin
    cur_mode = CFG_RESET.roi_mode;
    cur_count[0] = CFG_RESET.row_count;
    cur_count[1] = CFG_RESET.col_count;
    cur_count[2] = CFG_RESET.slice_count;
    cur_ratio = CFG_RESET.extend_ratio;
    cur_cube = CFG_RESET.cube_flag;
    cur_half = CFG_RESET.half_extent;
    clear_box();

    dir_tab.push_back(row_of(0, MODE_BETWEEN, 0, 0, 0, 0, 1, 1, BLANK_RES));
    dir_tab.push_back(row_of(0, MODE_BETWEEN, 0, 0, 0, 1, 1, 1,
                             bounds_res(0, LAST_POS, 0, LAST_POS, 0, 0)));
    dir_tab.push_back(row_of(0, MODE_BETWEEN, LAST_POS, LAST_POS, LAST_POS, 1, 1, 1,
                             bounds_res(0, LAST_POS, 0, LAST_POS, LAST_POS, LAST_POS)));
    dir_tab.push_back(row_of(0, MODE_BETWEEN, 5, 6, 7, 1, 0, 0, '0));
    dir_tab.push_back(row_of(0, MODE_BETWEEN, 100, 200, 300, 1, 0, 0, '0));
    dir_tab.push_back(row_of(0, MODE_BETWEEN, 900, 3, 1000, 0, 1, 1,
                             bounds_res(0, LAST_POS, 0, LAST_POS, 7, 300)));
    dir_tab.push_back(row_of(1, MODE_ABOVE, 10, 20, 30, 1, 1, 1,
                             bounds_res(0, LAST_POS, 0, LAST_POS, 30, LAST_POS)));
    dir_tab.push_back(row_of(1, MODE_BELOW, 10, 20, 30, 1, 1, 1,
                             bounds_res(0, LAST_POS, 0, LAST_POS, 0, 30)));
    dir_tab.push_back(row_of(1, MODE_FIXED, 10, 20, 30, 1, 1, 1,
                             bounds_res(10, 10, 20, 20, 30, 30)));
    dir_tab.push_back(row_of(1, MODE_RATIO, 0, 0, 0, 1, 1, 1, bounds_res(0, 0, 0, 0, 0, 0)));
    dir_tab.push_back(row_of(0, MODE_RATIO, 512, 512, 512, 1, 1, 0, '0));
    dir_tab.push_back(row_of(0, MODE_RATIO, LAST_POS, 0, 511, 1, 0, 0, '0));
    dir_tab.push_back(row_of(0, MODE_RATIO, 0, LAST_POS, 512, 1, 1, 0, '0));
    dir_tab.push_back(row_of(1, MODE_UNUSED_0, 3, 4, 5, 1, 0, 0, '0));
    dir_tab.push_back(row_of(0, MODE_UNUSED_0, 6, 7, 8, 1, 1, 1,
                             bounds_res(0, LAST_POS, 0, LAST_POS, 5, 8)));
    dir_tab.push_back(row_of(1, MODE_UNUSED_7, 0, 0, 0, 0, 1, 1, BLANK_RES));
    dir_tab.push_back(row_of(1, MODE_UNUSED_6, 1, 2, 3, 1, 1, 1,
                             bounds_res(0, LAST_POS, 0, LAST_POS, 3, 3)));
    dir_tab.push_back(row_of(1, MODE_BETWEEN, 1, 1, 1, 0, 0, 0, '0));
    dir_tab.push_back(row_of(0, MODE_BETWEEN, 2, 2, 2, 0, 1, 1, BLANK_RES));

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].set_mode) begin
        wait_idle();
        write_reg(REG_ROI_MODE, CFG_DATA_W'(dir_tab[i].mode));
        cfg_we_i <= 1'b0;
        setting_cnt++;
      end
      offer_voxel(dir_tab[i].vox, 1'b0, dir_tab[i].typed, dir_tab[i].want);
    end

    for (int p = 0; p < NUM_PHASES; p++) run_phase(p);

    push <= 1'b0;
    while (bounds_q.size() != 0) @(posedge clk_i);
    repeat (2 * IDLE_PAD) @(posedge clk_i);

    $display("run covered %0d voxels in %0d masks (%0d blank) over %0d register settings",
             voxel_cnt, mask_cnt, blank_cnt, setting_cnt);
    $display("input held back %0d cycles by a full queue, %0d mismatches",
             stall_cnt, mismatch_cnt);
    if (mismatch_cnt == 0) begin
      $display("mask_bbox_roi_bounds_unit_test passed");
    end else begin
      $display("mask_bbox_roi_bounds_unit_test failed");
    end
    $finish;
  end

endmodule

### mask_bbox_roi_bounds_unit.f
+incdir+design
design/mbrb_pkg.sv
design/mbrb_box_queue.sv
design/mbrb_front.sv
design/mbrb_back.sv
design/mask_bbox_roi_bounds_unit.sv
design/mbrb_checker.sv
verif/mask_bbox_roi_bounds_unit_test.sv
